>>> src/sarr_pkg.sv
// Shared types and codes for the shifting array block.
// Used by the controller, the datapath and the top level.
package sarr_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_DUMP   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD      = 2'd1,
      STATUS_NOTFOUND = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [31:0] value;
      logic [3:0]         position;
   } req_word_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] element;
      logic [3:0]         element_index;
      logic [4:0]         fill;
      logic               last;
   } rsp_word_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_INSERT,
      FSM_MATCH,
      FSM_DELETE,
      FSM_DUMP,
      FSM_RESP
   } fsm_type;

   typedef struct packed {
      logic capture;
      logic apply_insert;
      logic load_match;
      logic apply_delete;
      logic dump_first;
      logic dump_next;
   } ctl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    rsp_last;
   } dp_stat_type;

endpackage

>>> src/sarr_ctrl.sv
// Sequencer for the shifting array: steps each command word through the datapath.
// Depends on sarr_pkg.
module sarr_ctrl
   import sarr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output ctl_cmd_type ctl
);

   fsm_type state_ff;
   fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = FSM_MATCH;
            end
         end
         FSM_MATCH: begin
            // decode captured word; delete first registers the match vector
            case (stat.cmd)
               CMD_INSERT: state_in = FSM_INSERT;
               CMD_DELETE: begin
                  ctl.load_match = 1'b1;
                  state_in       = FSM_DELETE;
               end
               CMD_DUMP:   state_in = FSM_DUMP;
               default:    state_in = FSM_IDLE;
            endcase
         end
         FSM_INSERT: begin
            ctl.apply_insert = 1'b1;
            state_in         = FSM_RESP;
         end
         FSM_DELETE: begin
            ctl.apply_delete = 1'b1;
            state_in         = FSM_RESP;
         end
         FSM_DUMP: begin
            ctl.dump_first = 1'b1;
            state_in       = FSM_RESP;
         end
         FSM_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (stat.rsp_last) begin
                  state_in = FSM_IDLE;
               end else begin
                  ctl.dump_next = 1'b1;
               end
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

endmodule

>>> src/sarr_dp.sv
// Datapath: a row of word cells that shift, compare and rotate in place,
// plus the fill count and the result register. Depends on sarr_pkg.
module sarr_dp
   import sarr_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  ctl_cmd_type  ctl,
   output dp_stat_type  stat,
   output rsp_word_type rsp_word
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   logic signed [31:0] cell_ff [DEPTH];
   logic signed [31:0] cell_in [DEPTH];
   logic [DEPTH-1:0]   match_ff;
   logic [DEPTH-1:0]   match_in;
   logic [DEPTH-1:0]   from_hit;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [IW-1:0]      idx_ff;
   logic [IW-1:0]      idx_in;
   req_word_type       req_ff;
   rsp_word_type       rsp_ff;
   rsp_word_type       rsp_in;

   logic [31:0] count32;
   logic [31:0] pos32;
   logic [31:0] idx32;
   logic [31:0] fill32;
   logic        ins_ok;
   logic        found;
   logic        rotate;
   logic        hit_acc;

   assign count32 = 32'(count_ff);
   assign pos32   = 32'(req_ff.position);
   assign idx32   = 32'(idx_ff);
   assign ins_ok  = (pos32 <= count32) && (count32 < 32'(DEPTH));
   assign rotate  = ctl.dump_first || ctl.dump_next;

   always_comb begin
      hit_acc = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (cell_ff[i] == req_ff.value) && (32'(i) < count32);
         hit_acc     = hit_acc | match_ff[i];
         from_hit[i] = hit_acc;
      end
   end
   assign found = from_hit[DEPTH-1];

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
         if (ctl.apply_insert && ins_ok) begin
            if (32'(i) == pos32) begin
               cell_in[i] = req_ff.value;
            end else if (i > 0 && 32'(i) > pos32 && 32'(i) <= count32) begin
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (ctl.apply_delete && found) begin
            if (i < DEPTH - 1 && from_hit[i] && 32'(i) + 32'd1 < count32) begin
               cell_in[i] = cell_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end else if (rotate && 32'(i) < count32) begin
            // rotate valid words left by one; a full dump rotates them back into order
            if (32'(i) + 32'd1 == count32) begin
               cell_in[i] = cell_ff[0];
            end else if (i < DEPTH - 1) begin
               cell_in[i] = cell_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      rsp_in   = rsp_ff;
      if (ctl.apply_insert) begin
         if (ins_ok) begin
            count_in = count_ff + CW'(1);
         end
         rsp_in.status        = ins_ok ? STATUS_OK : STATUS_BAD;
         rsp_in.element       = '0;
         rsp_in.element_index = '0;
         rsp_in.last          = 1'b1;
      end else if (ctl.apply_delete) begin
         if (found) begin
            count_in = count_ff - CW'(1);
         end
         rsp_in.status        = found ? STATUS_OK : STATUS_NOTFOUND;
         rsp_in.element       = '0;
         rsp_in.element_index = '0;
         rsp_in.last          = 1'b1;
      end else if (ctl.dump_first) begin
         idx_in = IW'(1);
         if (count_ff == '0) begin
            rsp_in.status        = STATUS_EMPTY;
            rsp_in.element       = '0;
            rsp_in.element_index = '0;
            rsp_in.last          = 1'b1;
         end else begin
            rsp_in.status        = STATUS_OK;
            rsp_in.element       = cell_ff[0];
            rsp_in.element_index = '0;
            rsp_in.last          = (count32 == 32'd1);
         end
      end else if (ctl.dump_next) begin
         idx_in               = idx_ff + IW'(1);
         rsp_in.status        = STATUS_OK;
         rsp_in.element       = cell_ff[0];
         rsp_in.element_index = idx32[3:0];
         rsp_in.last          = (idx32 + 32'd1 == count32);
      end
      fill32      = 32'(count_in);
      rsp_in.fill = fill32[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
      if (ctl.capture) begin
         req_ff <= req_word;
      end
      if (ctl.load_match) begin
         match_ff <= match_in;
      end
   end

   assign stat.cmd      = req_ff.cmd;
   assign stat.rsp_last = rsp_ff.last;
   assign rsp_word      = rsp_ff;

endmodule

>>> src/shifting_array_insert_delete.sv
// Shifting array with insert, delete-first-match and dump of all words.
// After its first word, a dump gives one word per cycle while rsp_stall is low.
// One command at a time: the next word is accepted in the cycle after the last result is taken.
// Reset (synchronous) empties the array and returns the sequencer to idle.
module shifting_array_insert_delete
   import sarr_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   ctl_cmd_type ctl;
   dp_stat_type stat;

   sarr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   sarr_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .ctl      (ctl),
      .stat     (stat),
      .rsp_word (rsp_word)
   );

endmodule

>>> bench/sarr_checker.sv
// Watches both channels of the shifting array and predicts every result word.
// Needs sarr_pkg; reports mismatches, words still awaited and words checked.
module sarr_checker
   import sarr_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   output int           errors,
   output int           pending,
   output int           checked
);

   logic signed [31:0] slots [DEPTH];
   int                 fill_q;
   rsp_word_type       awaited [$];
   int                 error_total;
   int                 checked_total;

   function automatic int field_diff(input string name, input logic signed [32:0] want,
                                     input logic signed [32:0] got);
      if (got === want) return 0;
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
   endfunction

   task automatic predict_array_op(input req_word_type w);
      rsp_word_type r;
      int           hit;
      r      = '0;
      r.last = 1'b1;
      hit    = -1;
      case (w.cmd)
         CMD_INSERT: begin
            if (int'(w.position) > fill_q || fill_q >= DEPTH) begin
               r.status = STATUS_BAD;
            end else begin
               for (int i = fill_q; i > int'(w.position); i--) slots[i] = slots[i - 1];
               slots[w.position] = w.value;
               fill_q++;
               r.status = STATUS_OK;
            end
            r.fill = 5'(fill_q);
            awaited.push_back(r);
         end
         CMD_DELETE: begin
            for (int i = 0; i < fill_q; i++)
               if (hit < 0 && slots[i] == w.value) hit = i;
            if (hit < 0) begin
               r.status = STATUS_NOTFOUND;
            end else begin
               for (int i = hit; i + 1 < fill_q; i++) slots[i] = slots[i + 1];
               fill_q--;
               r.status = STATUS_OK;
            end
            r.fill = 5'(fill_q);
            awaited.push_back(r);
         end
         CMD_DUMP: begin
            if (fill_q == 0) begin
               r.status = STATUS_EMPTY;
               awaited.push_back(r);
            end else begin
               for (int i = 0; i < fill_q; i++) begin
                  r.status        = STATUS_OK;
                  r.element       = slots[i];
                  r.element_index = 4'(i);
                  r.fill          = 5'(fill_q);
                  r.last          = (i == fill_q - 1);
                  awaited.push_back(r);
               end
            end
         end
         default: ;  // spare code: no word out, array untouched
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (reset) begin
         fill_q = 0;
         awaited.delete();
         error_total   = 0;
         checked_total = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               $error("result word arrived with no command awaiting it");
               error_total++;
            end else begin
               want = awaited.pop_front();
               error_total += field_diff("status", want.status, rsp_word.status);
               error_total += field_diff("element", want.element, rsp_word.element);
               error_total += field_diff("element_index", want.element_index,
                                         rsp_word.element_index);
               error_total += field_diff("fill", want.fill, rsp_word.fill);
               error_total += field_diff("last", want.last, rsp_word.last);
               checked_total++;
            end
         end
         if (req_valid && !req_stall) predict_array_op(req_word);
      end
      errors  <= error_total;
      pending <= awaited.size();
      checked <= checked_total;
   end

endmodule

>>> bench/tb_shifting_array_insert_delete.sv
// Top of the shifting array bench: clock, reset, command stimulus and verdict.
// Needs sarr_pkg, shifting_array_insert_delete and sarr_checker.
module tb_shifting_array_insert_delete;
   import sarr_pkg::*;

   localparam int      DEPTH        = 16;
   localparam cmd_type CMD_SPARE    = cmd_type'(2'd3);
   localparam int      ITEMS_RANDOM = 245;
   localparam int      LONG_HOLD    = 120;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_word_type       req_word  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_word_type       rsp_word;
   int                 errors;
   int                 pending;
   int                 checked;
   logic               squeeze   = 1'b0;
   bit                 calm      = 1'b0;
   int                 words_sent = 0;
   logic signed [31:0] recent [$];

   always #10 clock = ~clock;

   shifting_array_insert_delete #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   sarr_checker #(.DEPTH(DEPTH)) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .errors    (errors),
      .pending   (pending),
      .checked   (checked)
   );

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return -32'sd1;
         3, 4:    return 32'($urandom_range(0, 5));
         default: return $urandom();
      endcase
   endfunction

   // Called at a clock edge; returns at the edge where the word is taken.
   task automatic send_word(input req_word_type w, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic send_fields(input cmd_type c, input logic signed [31:0] v,
                              input logic [3:0] p);
      req_word_type w;
      w.cmd      = c;
      w.value    = v;
      w.position = p;
      send_word(w, pick_gap());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic random_item(input bit grow, input bit pressed);
      req_word_type w;
      int           roll;
      roll       = $urandom_range(0, 99);
      w.value    = pick_value();
      w.position = 4'($urandom_range(0, 15));
      if (roll < (grow ? 65 : 20)) begin
         w.cmd = CMD_INSERT;
         if ($urandom_range(0, 1) == 0) w.position = 4'($urandom_range(0, 2));
         recent.push_back(w.value);
         if (recent.size() > 8) void'(recent.pop_front());
      end else if (roll < 80) begin
         w.cmd = CMD_DELETE;
         if (recent.size() > 0 && $urandom_range(0, 3) != 0)
            w.value = recent[$urandom_range(0, recent.size() - 1)];
      end else if (roll < 96) begin
         w.cmd = CMD_DUMP;
      end else begin
         w.cmd = CMD_SPARE;
      end
      send_word(w, pressed ? 0 : pick_gap());
   endtask

   // Result side: random stalls, quiet stretches, one long hold on request.
   initial begin : sink
      int hold_left;
      bit squeezed;
      bit quiet;
      hold_left = 0;
      squeezed  = 1'b0;
      quiet     = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 59) == 0) quiet = !quiet;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (squeeze && !squeezed) begin
            squeezed  = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 99) < 2) begin
            hold_left = $urandom_range(8, 30);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 30);
         end
      end
   end

   initial begin : stimulus
      bit grow;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_fields(CMD_DUMP, 32'sd0, 4'd0);
      send_fields(CMD_DELETE, 32'sd5, 4'd0);
      send_fields(CMD_INSERT, 32'sd9, 4'd1);
      send_fields(CMD_INSERT, 32'sh8000_0000, 4'd0);
      send_fields(CMD_INSERT, 32'sh7fff_ffff, 4'd1);
      send_fields(CMD_INSERT, -32'sd1, 4'd0);
      send_fields(CMD_INSERT, 32'sd0, 4'd1);
      send_fields(CMD_DUMP, 32'sd0, 4'd0);
      send_fields(CMD_DELETE, 32'sh7fff_ffff, 4'd0);
      send_fields(CMD_DELETE, 32'sd12345, 4'd0);
      send_fields(CMD_SPARE, 32'sh5a5a_a5a5, 4'd15);
      for (int i = 0; i < 12; i++)
         send_fields(CMD_INSERT, (i % 2 == 0) ? 32'sd7 : 32'sd1000 * i, 4'(i % 4));
      send_fields(CMD_INSERT, 32'sd7, 4'd15);
      send_fields(CMD_INSERT, 32'sd1, 4'd0);
      send_fields(CMD_DUMP, 32'sd0, 4'd0);
      send_fields(CMD_DELETE, 32'sd7, 4'd0);
      wait_drained();

      for (int n = 0; n < ITEMS_RANDOM; n++) begin
         grow = ((n / 40) % 2 == 0);
         if ($urandom_range(0, 19) == 0) calm = !calm;
         if (n == 100) begin
            squeeze <= 1'b1;
            repeat (6) random_item(grow, 1'b1);
            squeeze <= 1'b0;
         end
         if (n == 170) wait_drained();
         random_item(grow, 1'b0);
      end

      wait_drained();
      repeat (12) @(posedge clock);
      $display("Sent %0d command words, checked %0d result words.", words_sent, checked);
      $display("Covered empty and full arrays, bad positions, misses and first-match deletes.");
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin : watchdog
      #40_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> files.f
src/sarr_pkg.sv
src/sarr_ctrl.sv
src/sarr_dp.sv
src/shifting_array_insert_delete.sv
bench/sarr_checker.sv
bench/tb_shifting_array_insert_delete.sv
